// ===== src/pcx_rle_pixel_decoder_unit_macros.svh =====
// Assertion macros used by the checker file of the PCX RLE pixel decoder.
`ifndef PCX_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_PIXEL_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pcx_rle_pkg.sv =====
// Shared types and constants of the PCX RLE pixel decoder.
`timescale 1ns / 1ps
package pcx_rle_pkg;

    localparam int COORD_W  = 16;
    localparam int ADDR_W   = 20;
    localparam int COLOUR_W = 8;
    localparam int COUNT_W  = 6;
    localparam int SEG_W    = 16;

    localparam int LINE_PITCH_DEF  = 320;
    localparam int CMD_QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_SEGMENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd4;

    localparam logic [SEG_W-1:0]   FRAME_SEGMENT_RST = 16'd40960;
    localparam logic [COORD_W-1:0] WINDOW_LEFT_RST   = 16'd0;
    localparam logic [COORD_W-1:0] WINDOW_TOP_RST    = 16'd0;
    localparam logic [COORD_W-1:0] WINDOW_RIGHT_RST  = 16'd319;
    localparam logic [COORD_W-1:0] WINDOW_BOTTOM_RST = 16'd199;

    // a byte with both top bits set announces a run
    localparam logic [1:0] RUN_MARK = 2'b11;

    typedef struct packed {
        logic [SEG_W-1:0]   frame_segment;
        logic [COORD_W-1:0] window_left;
        logic [COORD_W-1:0] window_top;
        logic [COORD_W-1:0] window_right;
        logic [COORD_W-1:0] window_bottom;
    } cfg_t;

    typedef struct packed {
        logic               strobe;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
    } restart_t;

    // one classified input byte
    typedef struct packed {
        logic                is_prefix;
        logic [COUNT_W-1:0]  count;
        logic [COLOUR_W-1:0] colour;
    } cmd_t;

endpackage

// ===== src/pcx_rle_front.sv =====
// Front end: accept code bytes and classify them into prefix and paint commands.
`timescale 1ns / 1ps
module pcx_rle_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcx_rle_pkg::restart_t           restart,
    input  logic                            push,
    input  logic [pcx_rle_pkg::COLOUR_W-1:0] code_byte,
    input  logic                            q_full,
    output logic                            q_push,
    output pcx_rle_pkg::cmd_t               q_cmd
);
    import pcx_rle_pkg::*;

    logic               pending_reg;
    logic               pending_next;
    logic [COUNT_W-1:0] run_count_reg;
    logic [COUNT_W-1:0] run_count_next;
    logic               is_mark;

    assign is_mark = (code_byte[COLOUR_W-1:COLOUR_W-2] == RUN_MARK);
    assign q_push  = push && !q_full;

    always_comb
    begin
        pending_next     = pending_reg;
        run_count_next   = run_count_reg;
        q_cmd.is_prefix  = 1'b0;
        q_cmd.count      = COUNT_W'(1);
        q_cmd.colour     = code_byte;
        if (!pending_reg && is_mark)
        begin
            q_cmd.is_prefix = 1'b1;
            q_cmd.count     = code_byte[COUNT_W-1:0];
        end
        else if (pending_reg)
        begin
            q_cmd.count = run_count_reg;
        end
        if (q_push)
        begin
            if (!pending_reg && is_mark)
            begin
                pending_next   = 1'b1;
                run_count_next = code_byte[COUNT_W-1:0];
            end
            else
            begin
                pending_next   = 1'b0;
                run_count_next = '0;
            end
        end
        // a new image drops any half-seen run
        if (restart.strobe)
        begin
            pending_next   = 1'b0;
            run_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            run_count_reg <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

// ===== src/pcx_rle_cmd_queue.sv =====
// Short command queue between the front end and the pixel back end.
`timescale 1ns / 1ps
module pcx_rle_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcx_rle_pkg::cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output pcx_rle_pkg::cmd_t pop_cmd
);
    import pcx_rle_pkg::*;

    localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CMD_QUEUE_DEPTH - 1);

    cmd_t             slot_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (fill_reg == CNT_W'(CMD_QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/pcx_rle_back.sv =====
// Back end: walk the cursor, paint pixels and hold the result register.
`timescale 1ns / 1ps
module pcx_rle_back #(
    parameter int LINE_PITCH = pcx_rle_pkg::LINE_PITCH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pcx_rle_pkg::cfg_t                cfg,
    input  pcx_rle_pkg::restart_t            restart,
    input  logic                             q_valid,
    input  pcx_rle_pkg::cmd_t                q_cmd,
    output logic                             q_pop,
    input  logic                             pop,
    output logic                             out_valid,
    output logic [pcx_rle_pkg::ADDR_W-1:0]   pixel_address,
    output logic [pcx_rle_pkg::COORD_W-1:0]  pixel_column,
    output logic [pcx_rle_pkg::COORD_W-1:0]  pixel_row,
    output logic [pcx_rle_pkg::COLOUR_W-1:0] pixel_colour,
    output logic                             last_of_run
);
    import pcx_rle_pkg::*;

    localparam int PITCH_W = $clog2(LINE_PITCH + 1);
    localparam logic [PITCH_W-1:0] PITCH = PITCH_W'(LINE_PITCH);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PAINT = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic                       done_reg;
    logic                       done_next;
    logic [COORD_W-1:0]         cursor_col_reg;
    logic [COORD_W-1:0]         cursor_col_next;
    logic [COORD_W-1:0]         cursor_row_reg;
    logic [COORD_W-1:0]         cursor_row_next;
    logic [COLOUR_W-1:0]        colour_reg;
    logic [COLOUR_W-1:0]        colour_next;
    logic [COUNT_W-1:0]         remain_reg;
    logic [COUNT_W-1:0]         remain_next;
    logic [COORD_W:0]           col_reg;
    logic [COORD_W:0]           col_next;
    logic [ADDR_W-1:0]          prod_reg;
    logic [ADDR_W-1:0]          prod_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ADDR_W-1:0]          addr_reg;
    logic [ADDR_W-1:0]          addr_next;
    logic [COORD_W-1:0]         ocol_reg;
    logic [COORD_W-1:0]         ocol_next;
    logic [COORD_W-1:0]         orow_reg;
    logic [COORD_W-1:0]         orow_next;
    logic [COLOUR_W-1:0]        ocolour_reg;
    logic [COLOUR_W-1:0]        ocolour_next;
    logic                       olast_reg;
    logic                       olast_next;

    logic [PITCH_W+COORD_W-1:0] prod_full;
    logic [COORD_W:0]           col_after;
    logic [COORD_W:0]           next_row;
    logic                       col_ok;
    logic                       more;
    logic                       out_free;
    logic                       emit;
    logic                       last;
    logic                       finish;

    assign prod_full = PITCH * cursor_row_reg;
    assign next_row  = {1'b0, cursor_row_reg} + (COORD_W + 1)'(1);
    assign col_ok    = (col_reg <= {1'b0, cfg.window_right});
    assign more      = (remain_reg != '0) && col_ok;
    assign out_free  = !out_valid_reg || pop;

    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        colour_next     = colour_reg;
        remain_next     = remain_reg;
        col_next        = col_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        addr_next       = addr_reg;
        ocol_next       = ocol_reg;
        orow_next       = orow_reg;
        ocolour_next    = ocolour_reg;
        olast_next      = olast_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        last            = 1'b0;
        finish          = 1'b0;
        col_after       = col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (done_reg || (cursor_row_reg > cfg.window_bottom))
                    begin
                        done_next = 1'b1;
                    end
                    else if (!q_cmd.is_prefix)
                    begin
                        colour_next = q_cmd.colour;
                        remain_next = q_cmd.count;
                        col_next    = {1'b0, cursor_col_reg};
                        prod_next   = ADDR_W'(prod_full);
                        state_next  = ST_PAINT;
                    end
                end
            end
            ST_PAINT:
            begin
                if (more)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        last        = (remain_reg == COUNT_W'(1)) ||
                                      (col_reg[COORD_W-1:0] == cfg.window_right);
                        col_next    = col_reg + (COORD_W + 1)'(1);
                        remain_next = remain_reg - COUNT_W'(1);
                        col_after   = col_reg + (COORD_W + 1)'(1);
                        finish      = last;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of a colour byte: advance the cursor, wrap to the next row past the right edge
        if (finish)
        begin
            state_next = ST_IDLE;
            if (col_after > {1'b0, cfg.window_right})
            begin
                cursor_col_next = cfg.window_left;
                cursor_row_next = next_row[COORD_W-1:0];
                if (next_row[COORD_W] || (next_row > {1'b0, cfg.window_bottom}))
                begin
                    done_next = 1'b1;
                end
            end
            else
            begin
                cursor_col_next = col_after[COORD_W-1:0];
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next      = ADDR_W'({cfg.frame_segment, 4'b0000}) + prod_reg +
                             ADDR_W'(col_reg);
            ocol_next      = col_reg[COORD_W-1:0];
            orow_next      = cursor_row_reg;
            ocolour_next   = colour_reg;
            olast_next     = last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (restart.strobe)
        begin
            state_next      = ST_IDLE;
            done_next       = 1'b0;
            cursor_col_next = restart.left;
            cursor_row_next = restart.top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            cursor_col_reg <= WINDOW_LEFT_RST;
            cursor_row_reg <= WINDOW_TOP_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg  <= colour_next;
        remain_reg  <= remain_next;
        col_reg     <= col_next;
        prod_reg    <= prod_next;
        addr_reg    <= addr_next;
        ocol_reg    <= ocol_next;
        orow_reg    <= orow_next;
        ocolour_reg <= ocolour_next;
        olast_reg   <= olast_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_column  = ocol_reg;
    assign pixel_row     = orow_reg;
    assign pixel_colour  = ocolour_reg;
    assign last_of_run   = olast_reg;

endmodule

// ===== src/pcx_rle_pixel_decoder_unit.sv =====
// Top level of the PCX RLE pixel decoder: config registers, front, queue and back.
//
//   channel   direction  handshake            beat
//   input     in         push / full          code_byte
//   result    out        empty / pop          pixel_address, pixel_column, pixel_row,
//                                             pixel_colour, last_of_run
//   config    in         cfg_write (no wait)  cfg_index, cfg_data
//
// A prefix byte takes a single back-end step; a colour byte first picks up the command
// and forms LINE_PITCH*row, then paints one pixel per cycle while the result register
// is free. The back end's pixel loop sets the rate.
// Reset is asynchronous and active low; no clearing pass is needed.
// The two-entry command queue lets bytes keep arriving while a run is painted, and
// the result register lets a new pixel load in the same cycle the old one is popped.
`timescale 1ns / 1ps
module pcx_rle_pixel_decoder_unit #(
    parameter int LINE_PITCH = pcx_rle_pkg::LINE_PITCH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte input, queue style
    input  logic                                push,
    output logic                                full,
    input  logic [pcx_rle_pkg::COLOUR_W-1:0]    code_byte,
    // pixel output, queue style
    output logic                                empty,
    input  logic                                pop,
    output logic [pcx_rle_pkg::ADDR_W-1:0]      pixel_address,
    output logic [pcx_rle_pkg::COORD_W-1:0]     pixel_column,
    output logic [pcx_rle_pkg::COORD_W-1:0]     pixel_row,
    output logic [pcx_rle_pkg::COLOUR_W-1:0]    pixel_colour,
    output logic                                last_of_run,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [pcx_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcx_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcx_rle_pkg::*;

    logic [SEG_W-1:0]   frame_segment_reg;
    logic [SEG_W-1:0]   frame_segment_next;
    logic [COORD_W-1:0] window_left_reg;
    logic [COORD_W-1:0] window_left_next;
    logic [COORD_W-1:0] window_top_reg;
    logic [COORD_W-1:0] window_top_next;
    logic [COORD_W-1:0] window_right_reg;
    logic [COORD_W-1:0] window_right_next;
    logic [COORD_W-1:0] window_bottom_reg;
    logic [COORD_W-1:0] window_bottom_next;

    cfg_t     cfg;
    restart_t restart;
    logic     fq_push;
    cmd_t     fq_cmd;
    logic     q_full;
    logic     q_valid;
    cmd_t     q_cmd;
    logic     q_pop;
    logic     out_valid;

    // Register file; unknown indexes fall through and are dropped.
    always_comb
    begin
        frame_segment_next = frame_segment_reg;
        window_left_next   = window_left_reg;
        window_top_next    = window_top_reg;
        window_right_next  = window_right_reg;
        window_bottom_next = window_bottom_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_SEGMENT: frame_segment_next = cfg_data;
                REG_WINDOW_LEFT:   window_left_next   = cfg_data;
                REG_WINDOW_TOP:    window_top_next    = cfg_data;
                REG_WINDOW_RIGHT:  window_right_next  = cfg_data;
                REG_WINDOW_BOTTOM: window_bottom_next = cfg_data;
                default:           frame_segment_next = frame_segment_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_segment_reg <= FRAME_SEGMENT_RST;
            window_left_reg   <= WINDOW_LEFT_RST;
            window_top_reg    <= WINDOW_TOP_RST;
            window_right_reg  <= WINDOW_RIGHT_RST;
            window_bottom_reg <= WINDOW_BOTTOM_RST;
        end
        else
        begin
            frame_segment_reg <= frame_segment_next;
            window_left_reg   <= window_left_next;
            window_top_reg    <= window_top_next;
            window_right_reg  <= window_right_next;
            window_bottom_reg <= window_bottom_next;
        end
    end

    assign cfg.frame_segment = frame_segment_reg;
    assign cfg.window_left   = window_left_reg;
    assign cfg.window_top    = window_top_reg;
    assign cfg.window_right  = window_right_reg;
    assign cfg.window_bottom = window_bottom_reg;

    // Moving the window origin starts a new image at the new origin.
    assign restart.strobe = cfg_write &&
                            ((cfg_index == REG_WINDOW_LEFT) || (cfg_index == REG_WINDOW_TOP));
    assign restart.left   = window_left_next;
    assign restart.top    = window_top_next;

    pcx_rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .push      (push),
        .code_byte (code_byte),
        .q_full    (q_full),
        .q_push    (fq_push),
        .q_cmd     (fq_cmd)
    );

    pcx_rle_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_cmd  (fq_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    pcx_rle_back #(
        .LINE_PITCH (LINE_PITCH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .restart       (restart),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .pop           (pop),
        .out_valid     (out_valid),
        .pixel_address (pixel_address),
        .pixel_column  (pixel_column),
        .pixel_row     (pixel_row),
        .pixel_colour  (pixel_colour),
        .last_of_run   (last_of_run)
    );

    assign full  = q_full;
    assign empty = !out_valid;

endmodule

// ===== src/pcx_rle_checker.sv =====
// Port-level assertions for the PCX RLE pixel decoder, bound to its top level.
`timescale 1ns / 1ps
`include "pcx_rle_pixel_decoder_unit_macros.svh"
module pcx_rle_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic [pcx_rle_pkg::ADDR_W-1:0]     pixel_address,
    input logic [pcx_rle_pkg::COORD_W-1:0]    pixel_column,
    input logic [pcx_rle_pkg::COORD_W-1:0]    pixel_row,
    input logic [pcx_rle_pkg::COLOUR_W-1:0]   pixel_colour,
    input logic                               last_of_run
);
    import pcx_rle_pkg::*;

    // a waiting beat holds until popped
    `PCX_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(pixel_address) && $stable(pixel_column) && $stable(last_of_run), "result changed while stalled")

    // inside a run the next pixel follows at once, one column to the right
    `PCX_ASSERT_NEXT(a_run_step, clk, rst_n, !empty && pop && !last_of_run, !empty && (pixel_column == COORD_W'($past(pixel_column) + 16'd1)) && (pixel_row == $past(pixel_row)) && (pixel_colour == $past(pixel_colour)), "run pixel out of step")

    // linear address advances with the column
    `PCX_ASSERT_NEXT(a_addr_step, clk, rst_n, !empty && pop && !last_of_run, pixel_address == ADDR_W'($past(pixel_address) + 20'd1), "run address out of step")

    // a run can only continue while the column is below the last one
    `PCX_ASSERT_NOW(a_col_room, clk, rst_n, !empty && !last_of_run, pixel_column != 16'hFFFF, "run continues past last column")

endmodule

bind pcx_rle_pixel_decoder_unit pcx_rle_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .pixel_address (pixel_address),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .pixel_colour  (pixel_colour),
    .last_of_run   (last_of_run)
);

// ===== verif/tb_pcx_rle_pixel_decoder_unit.sv =====
// Self-checking testbench of the PCX RLE pixel decoder: directed stream, then random images.
`timescale 1ns / 1ps
module tb_pcx_rle_pixel_decoder_unit;
    import pcx_rle_pkg::*;

    localparam int LINE_PITCH = LINE_PITCH_DEF;

    // Cycles to let the back end finish bytes that paint nothing (prefixes, dropped
    // colours, ignored bytes) before a register write or the final verdict.
    localparam int DRAIN_CYCLES = 16;

    // Give up after this many cycles in which neither side moves a beat.
    localparam int WATCHDOG_LIMIT = 2000;

    // Keep the log short if the design is badly broken; mismatches still count.
    localparam int PRINT_CAP = 100;

    // Register indexes with no register behind them; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } pixel_t;

    // One directed byte. Where 'checked' is set, the pixel count and (for a single
    // pixel) its position are typed in; the colour of that pixel is the byte itself.
    typedef struct packed {
        logic [COLOUR_W-1:0] code;
        logic                checked;
        logic [6:0]          npix;
        logic [ADDR_W-1:0]   address;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
    } stim_row_t;

    localparam int STIM_ROWS = 24;

    // Runs under the reset window: 320 x 200 at segment 40960, base 0xA0000.
    stim_row_t stim_table [STIM_ROWS] = '{
        '{8'h00, 1'b1, 7'd1, 20'hA0000, 16'd0, 16'd0},   // smallest literal
        '{8'hBF, 1'b1, 7'd1, 20'hA0001, 16'd1, 16'd0},   // largest literal
        '{8'h3F, 1'b1, 7'd1, 20'hA0002, 16'd2, 16'd0},
        '{8'h40, 1'b1, 7'd1, 20'hA0003, 16'd3, 16'd0},
        '{8'h80, 1'b1, 7'd1, 20'hA0004, 16'd4, 16'd0},
        '{8'hC0, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},   // zero-count run prefix
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},   // its colour paints nothing
        '{8'hC1, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hC1, 1'b1, 7'd1, 20'hA0005, 16'd5, 16'd0},   // run of one, prefix-like colour
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},   // longest run
        '{8'hAA, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hFF, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hE5, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'h00, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'h12, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'h34, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hFF, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'h56, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0},   // clipped at the right edge
        '{8'h7F, 1'b1, 7'd1, 20'hA0140, 16'd0, 16'd1},   // first pixel of row one
        '{8'hC2, 1'b1, 7'd0, 20'h0,     16'd0, 16'd0},
        '{8'hC0, 1'b0, 7'd0, 20'h0,     16'd0, 16'd0}
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [COLOUR_W-1:0]    code_byte;
    logic                   empty;
    logic                   pop;
    logic [ADDR_W-1:0]      pixel_address;
    logic [COORD_W-1:0]     pixel_column;
    logic [COORD_W-1:0]     pixel_row;
    logic [COLOUR_W-1:0]    pixel_colour;
    logic                   last_of_run;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Typed expectation travelling with the byte on the bus (directed rows only).
    logic                   table_check;
    logic [6:0]             table_npix;
    pixel_t                 table_pixel;

    // Idle percentages of sender and receiver for the current stretch.
    int                     tx_idle_pct;
    int                     rx_idle_pct;

    int                     mismatches = 0;
    int                     quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Shadow of the decoder: window registers and drawing cursor
    // ------------------------------------------------------------------
    logic [SEG_W-1:0]       shadow_segment;
    logic [COORD_W-1:0]     shadow_left;
    logic [COORD_W-1:0]     shadow_top;
    logic [COORD_W-1:0]     shadow_right;
    logic [COORD_W-1:0]     shadow_bottom;
    logic [COORD_W-1:0]     cursor_col;
    logic [COORD_W-1:0]     cursor_row;
    logic [COUNT_W-1:0]     armed_count;
    logic                   run_armed;
    logic                   image_finished;

    pixel_t                 pixel_q[$];     // pixels still owed by the design
    pixel_t                 first_painted;  // first pixel of the latest colour byte

    pcx_rle_pixel_decoder_unit #(
        .LINE_PITCH(LINE_PITCH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .code_byte    (code_byte),
        .empty        (empty),
        .pop          (pop),
        .pixel_address(pixel_address),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .pixel_colour (pixel_colour),
        .last_of_run  (last_of_run),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Put the cursor at the window origin and drop any half-read run.
    function automatic void restart_image();
        cursor_col     = shadow_left;
        cursor_row     = shadow_top;
        armed_count    = '0;
        run_armed      = 1'b0;
        image_finished = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_SEGMENT: shadow_segment = data;
            REG_WINDOW_LEFT:
            begin
                shadow_left = data;
                restart_image();
            end
            REG_WINDOW_TOP:
            begin
                shadow_top = data;
                restart_image();
            end
            REG_WINDOW_RIGHT:  shadow_right  = data;
            REG_WINDOW_BOTTOM: shadow_bottom = data;
            default: ;
        endcase
    endfunction

    // Advance the shadow by one byte, queue the pixels it paints, return how many.
    function automatic int paint_byte(input logic [COLOUR_W-1:0] b);
        int unsigned remaining;
        int unsigned col;
        int unsigned next_row;
        int          produced;
        logic [31:0] linear;
        pixel_t      px;
        produced = 0;
        // Row beyond bottom: latch done and swallow the byte.
        if (image_finished || cursor_row > shadow_bottom)
        begin
            image_finished = 1'b1;
            return 0;
        end
        if (!run_armed && b[7:6] == RUN_MARK)
        begin
            run_armed   = 1'b1;
            armed_count = b[COUNT_W-1:0];
            return 0;
        end
        if (run_armed)
        begin
            remaining   = armed_count;
            run_armed   = 1'b0;
            armed_count = '0;
        end
        else
        begin
            remaining = 1;
        end
        // Paint from the cursor; drop whatever falls past the right edge.
        col = cursor_col;
        while (remaining != 0 && col <= shadow_right)
        begin
            linear     = shadow_segment * 16 + LINE_PITCH * cursor_row + col;
            px.address = linear[ADDR_W-1:0];
            px.column  = col[COORD_W-1:0];
            px.row     = cursor_row;
            px.colour  = b;
            px.last    = (remaining == 1) || (col == shadow_right);
            if (produced == 0)
                first_painted = px;
            pixel_q.push_back(px);
            produced++;
            remaining--;
            col++;
        end
        // Wrap to the next row; a step past the last row or past 65535 ends the image.
        if (col > shadow_right)
        begin
            cursor_col = shadow_left;
            next_row   = cursor_row + 1;
            if (next_row > 32'hFFFF || next_row > shadow_bottom)
                image_finished = 1'b1;
            cursor_row = next_row[COORD_W-1:0];
        end
        else
        begin
            cursor_col = col[COORD_W-1:0];
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string tag, input string field,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s %s got 0x%0h want 0x%0h", tag, field, got, want));
    endtask

    task automatic compare_pixel(input string tag, input pixel_t got,
                                 input pixel_t want);
        check_field(tag, "pixel_address", got.address, want.address);
        check_field(tag, "pixel_column",  got.column,  want.column);
        check_field(tag, "pixel_row",     got.row,     want.row);
        check_field(tag, "pixel_colour",  got.colour,  want.colour);
        check_field(tag, "last_of_run",   got.last,    want.last);
    endtask

    // Monitor: everything is sampled at the rising edge, before this edge's updates
    // land, so the values seen are the ones the design saw.
    always @(posedge clk)
    begin : monitor
        int     produced;
        logic   moved;
        pixel_t got_px;
        pixel_t want_px;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            // Input beat: predict first, so a pixel that leaves on this edge finds it.
            if (push && !full)
            begin
                moved    = 1'b1;
                produced = paint_byte(code_byte);
                if (table_check)
                begin
                    if (produced != table_npix)
                        report_mismatch($sformatf("byte 0x%02h paints %0d pixels, table says %0d",
                                                  code_byte, produced, table_npix));
                    else if (produced != 0)
                        compare_pixel("table", first_painted, table_pixel);
                end
            end
            // Result beat: compare against the oldest owed pixel.
            if (pop && !empty)
            begin
                moved            = 1'b1;
                got_px.address   = pixel_address;
                got_px.column    = pixel_column;
                got_px.row       = pixel_row;
                got_px.colour    = pixel_colour;
                got_px.last      = last_of_run;
                if (pixel_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel at column %0d row %0d",
                                              pixel_column, pixel_row));
                end
                else
                begin
                    want_px = pixel_q.pop_front();
                    compare_pixel("pixel", got_px, want_px);
                end
            end
            // Watchdog: count cycles without a beat on either side.
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d pixels owed",
                         WATCHDOG_LIMIT, pixel_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pop at random at the current rate
    // ------------------------------------------------------------------
    always @(posedge clk)
        pop <= ($urandom_range(99) >= rx_idle_pct);

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Offer one byte, with random gaps ahead of it, and hold it until it is taken.
    // Leave push high afterwards so back-to-back beats need no extra edge.
    task automatic send_byte(input logic [COLOUR_W-1:0] b, input logic checked,
                             input logic [6:0] npix, input pixel_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        code_byte   <= b;
        table_check <= checked;
        table_npix  <= npix;
        table_pixel <= want;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Wait until every owed pixel is out, then let the back end drain bytes
    // that paint nothing. Step one edge first so the last beat is predicted.
    task automatic settle();
        do
            @(posedge clk);
        while (pixel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random stream, mostly well formed: prefix + colour pairs and literals, with
    // some raw noise. Stop after a few units once the image is done.
    task automatic send_stream(input int units);
        int                 live;
        int                 dead;
        int                 pick;
        logic [COUNT_W-1:0] run_len;
        live = 0;
        dead = 0;
        while (live < units && dead < 3)
        begin
            if (image_finished)
                dead++;
            else
                live++;
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    run_len = COUNT_W'($urandom_range(7));
                else if (pick < 90)
                    run_len = COUNT_W'($urandom_range(62, 8));
                else
                    run_len = '1;
                send_byte({RUN_MARK, run_len}, 1'b0, '0, '0);
                send_byte(COLOUR_W'($urandom_range(255)), 1'b0, '0, '0);
            end
            else if (pick < 90)
            begin
                send_byte(COLOUR_W'($urandom_range(191)), 1'b0, '0, '0);
            end
            else
            begin
                send_byte(COLOUR_W'($urandom_range(255)), 1'b0, '0, '0);
            end
        end
        push <= 1'b0;
    endtask

    // Program a whole window while idle, then paint into it.
    task automatic run_image(input logic [SEG_W-1:0] seg, input logic [COORD_W-1:0] left,
                             input logic [COORD_W-1:0] top, input logic [COORD_W-1:0] right,
                             input logic [COORD_W-1:0] bottom, input int units);
        settle();
        write_reg(REG_FRAME_SEGMENT, seg);
        write_reg(REG_WINDOW_RIGHT, right);
        write_reg(REG_WINDOW_BOTTOM, bottom);
        write_reg(REG_WINDOW_LEFT, left);
        write_reg(REG_WINDOW_TOP, top);
        send_stream(units);
    endtask

    initial
    begin : stimulus
        pixel_t want;
        rst_n       = 1'b0;
        push        = 1'b0;
        code_byte   = '0;
        pop         = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_FRAME_SEGMENT;
        cfg_data    = '0;
        table_check = 1'b0;
        table_npix  = '0;
        table_pixel = '0;

        // Shadow registers start at their reset values.
        shadow_segment = FRAME_SEGMENT_RST;
        shadow_left    = WINDOW_LEFT_RST;
        shadow_top     = WINDOW_TOP_RST;
        shadow_right   = WINDOW_RIGHT_RST;
        shadow_bottom  = WINDOW_BOTTOM_RST;
        restart_image();

        // Sender sparse, receiver slow.
        set_idle(35, 76);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream under the reset window.
        for (int i = 0; i < STIM_ROWS; i++)
        begin
            want.address = stim_table[i].address;
            want.column  = stim_table[i].column;
            want.row     = stim_table[i].row;
            want.colour  = stim_table[i].code;
            want.last    = 1'b1;
            send_byte(stim_table[i].code, stim_table[i].checked, stim_table[i].npix, want);
        end
        push <= 1'b0;

        // Small window at a random segment: rows wrap and the image finishes.
        run_image(SEG_W'($urandom_range(65535)), 16'd5, 16'd3, 16'd40, 16'd4, 12);
        // Extremes: top segment wraps the address, columns run to 65535 and the
        // second row steps the row counter past 65535.
        run_image(16'hFFFF, 16'd65530, 16'd65534, 16'hFFFF, 16'hFFFF, 10);
        // Left past right: every colour byte is dropped and only moves the row.
        run_image(16'h0000, 16'd20, 16'd0, 16'd10, 16'd5, 10);

        // Receiver eager, sender sparse.
        set_idle(76, 35);

        // Top below bottom: the very first byte finds the image done.
        run_image(SEG_W'($urandom_range(65535)), 16'd0, 16'd9, 16'd7, 16'd4, 4);
        // All registers zero: a one-pixel image.
        run_image(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6);
        // Pull the bottom edge above the cursor without restarting the image.
        run_image(16'h0100, 16'd0, 16'd0, 16'd15, 16'd50, 10);
        settle();
        write_reg(REG_WINDOW_BOTTOM, 16'd0);
        send_stream(3);
        // Writes to unused indexes must leave the window alone; a top write restarts.
        settle();
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(65535)));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(65535)));
        write_reg(REG_WINDOW_BOTTOM, 16'd60);
        write_reg(REG_WINDOW_TOP, 16'd2);
        send_stream(6);

        // Neither side idles.
        set_idle(0, 0);

        // Reset-sized window, then one at the top of the column range.
        run_image(FRAME_SEGMENT_RST, WINDOW_LEFT_RST, WINDOW_TOP_RST,
                  WINDOW_RIGHT_RST, WINDOW_BOTTOM_RST, 10);
        run_image(SEG_W'($urandom_range(65535)), 16'd65400, 16'd100,
                  16'hFFFF, 16'hFFFF, 10);

        // Drain everything, then give the verdict.
        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== pcx_rle_pixel_decoder_unit.f =====
+incdir+src
src/pcx_rle_pkg.sv
src/pcx_rle_front.sv
src/pcx_rle_cmd_queue.sv
src/pcx_rle_back.sv
src/pcx_rle_pixel_decoder_unit.sv
src/pcx_rle_checker.sv
verif/tb_pcx_rle_pixel_decoder_unit.sv
